// ===== rtl/cesc_pkg.sv =====
// Shared types and character constants of the escape sequence decoder.
`default_nettype none

package cesc_pkg;

   localparam int unsigned BUNDLE_BYTES = 3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_A         = 8'h61;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_V         = 8'h76;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

   localparam logic [7:0] CTRL_BEL = 8'h07;
   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_HT  = 8'h09;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_VT  = 8'h0B;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_CR  = 8'h0D;

   typedef struct packed {
      logic [1:0]                        count;
      logic [BUNDLE_BYTES-1:0][7:0]      data;
      logic                              last;
   } cesc_bundle_type;

endpackage

`default_nettype wire

// ===== rtl/cesc_intf.sv =====
// Request and response channel interfaces of the escape sequence decoder.
`default_nettype none

interface cesc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface cesc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_done;

   modport source (output valid, output out_byte, output run_last, output string_done,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input string_done,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/cesc_front.sv =====
// Front end: accepts raw bytes, tracks escape state and builds result bundles.
`default_nettype none

module cesc_front
   import cesc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   cesc_req_if.sink         req_chan,
   input  wire logic        q_full,
   output logic             q_push,
   output cesc_bundle_type  q_data
);

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_HEX    = 2'd2;
   localparam logic [1:0] MODE_OCT    = 2'd3;

   logic [1:0]      mode_ff, mode_in;
   logic [1:0]      digits_ff, digits_in;
   logic [8:0]      pending_ff, pending_in;
   cesc_bundle_type bun;
   logic            accept;
   logic            run_normal;
   logic [7:0]      b;
   logic            eos;
   logic [4:0]      hex;
   logic            oct_ok;

   function automatic cesc_bundle_type add_byte(cesc_bundle_type cur, logic [7:0] v);
      cesc_bundle_type nxt;
      nxt = cur;
      if (cur.count < 2'(BUNDLE_BYTES)) begin
         nxt.data[cur.count] = v;
         nxt.count = cur.count + 2'd1;
      end
      return nxt;
   endfunction

   function automatic logic [4:0] hex_value(logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
                   (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   assign b      = req_chan.in_byte;
   assign eos    = req_chan.end_of_string;
   assign hex    = hex_value(b);
   assign oct_ok = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   always_comb begin
      bun        = '0;
      mode_in    = mode_ff;
      digits_in  = digits_ff;
      pending_in = pending_ff;
      run_normal = 1'b0;
      unique case (mode_ff)
         MODE_NORMAL: begin
            run_normal = 1'b1;
         end
         MODE_ESC: begin
            mode_in = MODE_NORMAL;
            unique case (b)
               CHAR_BACKSLASH: bun = add_byte(bun, CHAR_BACKSLASH);
               CHAR_QUOTE:     bun = add_byte(bun, CHAR_QUOTE);
               CHAR_DQUOTE:    bun = add_byte(bun, CHAR_DQUOTE);
               CHAR_A:         bun = add_byte(bun, CTRL_BEL);
               CHAR_B:         bun = add_byte(bun, CTRL_BS);
               CHAR_F:         bun = add_byte(bun, CTRL_FF);
               CHAR_N:         bun = add_byte(bun, CTRL_LF);
               CHAR_R:         bun = add_byte(bun, CTRL_CR);
               CHAR_T:         bun = add_byte(bun, CTRL_HT);
               CHAR_V:         bun = add_byte(bun, CTRL_VT);
               CHAR_X: begin
                  if (eos) begin
                     bun = add_byte(bun, CHAR_BACKSLASH);
                     bun = add_byte(bun, CHAR_X);
                  end else begin
                     mode_in    = MODE_HEX;
                     digits_in  = 2'd0;
                     pending_in = '0;
                  end
               end
               default: begin
                  if (oct_ok) begin
                     pending_in = {6'd0, b[2:0]};
                     digits_in  = 2'd1;
                     if (eos) begin
                        bun = add_byte(bun, {5'd0, b[2:0]});
                     end else begin
                        mode_in = MODE_OCT;
                     end
                  end else begin
                     bun = add_byte(bun, CHAR_BACKSLASH);
                     bun = add_byte(bun, b);
                  end
               end
            endcase
         end
         MODE_HEX: begin
            if (hex[4]) begin
               pending_in = {pending_ff[4:0], hex[3:0]};
               digits_in  = digits_ff + 2'd1;
               if (digits_in >= 2'd2 || eos) begin
                  bun     = add_byte(bun, pending_in[7:0]);
                  mode_in = MODE_NORMAL;
               end
            end else begin
               if (digits_ff == 2'd0) begin
                  bun = add_byte(bun, CHAR_BACKSLASH);
                  bun = add_byte(bun, CHAR_X);
               end else begin
                  bun = add_byte(bun, pending_ff[7:0]);
               end
               mode_in    = MODE_NORMAL;
               run_normal = 1'b1;
            end
         end
         MODE_OCT: begin
            if (oct_ok) begin
               pending_in = {pending_ff[5:0], b[2:0]};
               digits_in  = digits_ff + 2'd1;
               if (digits_in == 2'd3 || digits_in == 2'd0 || eos) begin
                  bun     = add_byte(bun, pending_in[7:0]);
                  mode_in = MODE_NORMAL;
               end
            end else begin
               bun        = add_byte(bun, pending_ff[7:0]);
               mode_in    = MODE_NORMAL;
               run_normal = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
         end
      endcase

      if (run_normal) begin
         if (b == CHAR_BACKSLASH) begin
            if (eos) begin
               bun = add_byte(bun, CHAR_BACKSLASH);
            end else begin
               mode_in = MODE_ESC;
            end
         end else begin
            bun = add_byte(bun, b);
         end
      end
      bun.last = eos;
   end

   assign q_push = accept && (bun.count != 2'd0);
   assign q_data = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_NORMAL;
         digits_ff  <= '0;
         pending_ff <= '0;
      end else if (accept) begin
         if (eos) begin
            mode_ff    <= MODE_NORMAL;
            digits_ff  <= '0;
            pending_ff <= '0;
         end else begin
            mode_ff    <= mode_in;
            digits_ff  <= digits_in;
            pending_ff <= pending_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cesc_queue.sv =====
// Bundle queue between the front end and the output serialiser.
`default_nettype none

module cesc_queue
   import cesc_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire cesc_bundle_type  push_data,
   output logic                  full,
   input  wire logic             pop,
   output cesc_bundle_type       pop_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cesc_bundle_type    store [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cesc_back.sv =====
// Back end: unpacks queued bundles into one decoded byte per response.
`default_nettype none

module cesc_back
   import cesc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire cesc_bundle_type  q_data,
   output logic                  q_pop,
   cesc_rsp_if.source            rsp_chan
);

   logic            busy_ff, busy_in;
   cesc_bundle_type bun_ff, bun_in;
   logic [1:0]      idx_ff, idx_in;
   logic            take;
   logic            at_last;
   logic            free;

   assign at_last = (idx_ff == bun_ff.count - 2'd1);
   assign take    = busy_ff && rsp_chan.ready;
   assign free    = !busy_ff || (take && at_last);
   assign q_pop   = free && !q_empty;

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.out_byte    = bun_ff.data[idx_ff];
   assign rsp_chan.run_last    = at_last;
   assign rsp_chan.string_done = at_last && bun_ff.last;

   always_comb begin
      busy_in = busy_ff;
      bun_in  = bun_ff;
      idx_in  = idx_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         bun_in  = q_data;
         idx_in  = '0;
      end else if (free) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      bun_ff <= bun_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/c_escape_sequence_decoder.sv =====
// Top level of the C string escape sequence decoder.
//
// Requests on req_chan carry one raw byte and an end-of-string flag; responses on
// rsp_chan carry one decoded byte, run_last on the final byte caused by a request
// and string_done on the final byte of the string. A request yields zero to three
// responses; one that yields none (a backslash, a pending digit) leaves no trace.
// The front end decodes a request in the cycle it is accepted and writes its
// responses as one bundle into a queue of QUEUE_DEPTH bundles; the back end sends
// them one per cycle while the receiver is ready. Throughput with a ready receiver:
// one request per cycle while each yields at most one byte; otherwise the output
// side sets the pace at one byte per cycle and the queue absorbs bursts. A stalled
// receiver holds the current response; requests keep being taken until the queue
// is full, then req_chan.ready drops. Reset returns the decoder to normal mode and
// empties the queue.
`default_nettype none

module c_escape_sequence_decoder
   import cesc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   cesc_req_if.sink    req_chan,
   cesc_rsp_if.source  rsp_chan
);

   logic            q_full;
   logic            q_empty;
   logic            q_push;
   logic            q_pop;
   cesc_bundle_type q_wr_data;
   cesc_bundle_type q_rd_data;

   cesc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   cesc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   cesc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== tb/sv/c_escape_sequence_decoder_tb.sv =====
// Self-checking testbench of the C string escape sequence decoder.
module c_escape_sequence_decoder_tb
   import cesc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 20;

   localparam logic [7:0] SIMPLE_ESC [10] = '{CHAR_BACKSLASH, CHAR_QUOTE, CHAR_DQUOTE,
      CHAR_A, CHAR_B, CHAR_F, CHAR_N, CHAR_R, CHAR_T, CHAR_V};

   typedef enum logic [1:0] {MODE_PLAIN, MODE_ESCAPE, MODE_HEXRUN, MODE_OCTRUN} mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
   } decoded_type;

   logic clock;
   logic reset;

   cesc_req_if req_chan ();
   cesc_rsp_if rsp_chan ();

   c_escape_sequence_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mode_type    dec_mode;
   logic [1:0]  dec_digits;
   logic [8:0]  dec_value;
   logic [7:0]  step_bytes[$];
   decoded_type expected_bytes[$];
   logic [7:0]  text_bytes[$];

   int error_count = 0;
   int sent_count;
   int quiet_cycles = 0;
   int send_idle_pct;
   int recv_idle_pct;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int hex_value(input logic [7:0] b);
      if (b >= CHAR_ZERO && b <= CHAR_NINE) return int'(b - CHAR_ZERO);
      if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) return int'(b - CHAR_LOWER_A) + 10;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) return int'(b - CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   function automatic void add_step(input logic [7:0] v);
      step_bytes.insert(step_bytes.size(), v);
   endfunction

   function automatic void add_text(input logic [7:0] v);
      text_bytes.insert(text_bytes.size(), v);
   endfunction

   function automatic void decode_plain(input logic [7:0] b, input logic eos);
      if (b == CHAR_BACKSLASH && !eos) begin
         dec_mode = MODE_ESCAPE;
      end else begin
         add_step(b);
      end
   endfunction

   function automatic void decode_escape(input logic [7:0] b, input logic eos);
      dec_mode = MODE_PLAIN;
      case (b)
         CHAR_BACKSLASH: add_step(CHAR_BACKSLASH);
         CHAR_QUOTE: add_step(CHAR_QUOTE);
         CHAR_DQUOTE: add_step(CHAR_DQUOTE);
         CHAR_A: add_step(CTRL_BEL);
         CHAR_B: add_step(CTRL_BS);
         CHAR_F: add_step(CTRL_FF);
         CHAR_N: add_step(CTRL_LF);
         CHAR_R: add_step(CTRL_CR);
         CHAR_T: add_step(CTRL_HT);
         CHAR_V: add_step(CTRL_VT);
         CHAR_X: begin
            if (eos) begin
               add_step(CHAR_BACKSLASH);
               add_step(CHAR_X);
            end else begin
               dec_mode = MODE_HEXRUN;
               dec_digits = 2'd0;
               dec_value = 9'd0;
            end
         end
         default: begin
            if (b >= CHAR_ZERO && b <= CHAR_SEVEN) begin
               dec_value = {6'd0, b[2:0]};
               dec_digits = 2'd1;
               if (eos) add_step(dec_value[7:0]);
               else dec_mode = MODE_OCTRUN;
            end else begin
               add_step(CHAR_BACKSLASH);
               add_step(b);
            end
         end
      endcase
   endfunction

   function automatic void decode_request(input logic [7:0] b, input logic eos);
      int          digit;
      decoded_type entry;
      step_bytes.delete();
      case (dec_mode)
         MODE_PLAIN: decode_plain(b, eos);
         MODE_ESCAPE: decode_escape(b, eos);
         MODE_HEXRUN: begin
            digit = hex_value(b);
            if (digit >= 0) begin
               dec_value = {dec_value[4:0], digit[3:0]};
               dec_digits = dec_digits + 2'd1;
               if (dec_digits >= 2'd2 || eos) begin
                  add_step(dec_value[7:0]);
                  dec_mode = MODE_PLAIN;
               end
            end else begin
               if (dec_digits == 2'd0) begin
                  add_step(CHAR_BACKSLASH);
                  add_step(CHAR_X);
               end else begin
                  add_step(dec_value[7:0]);
               end
               dec_mode = MODE_PLAIN;
               decode_plain(b, eos);
            end
         end
         default: begin
            if (b >= CHAR_ZERO && b <= CHAR_SEVEN) begin
               dec_value = {dec_value[5:0], b[2:0]};
               dec_digits = dec_digits + 2'd1;
               if (dec_digits >= 2'd3 || dec_digits == 2'd0 || eos) begin
                  add_step(dec_value[7:0]);
                  dec_mode = MODE_PLAIN;
               end
            end else begin
               add_step(dec_value[7:0]);
               dec_mode = MODE_PLAIN;
               decode_plain(b, eos);
            end
         end
      endcase
      foreach (step_bytes[i]) begin
         entry.out_byte = step_bytes[i];
         entry.run_last = (i == step_bytes.size() - 1);
         entry.string_done = eos && (i == step_bytes.size() - 1);
         expected_bytes.insert(expected_bytes.size(), entry);
      end
      if (eos) begin
         dec_mode = MODE_PLAIN;
         dec_digits = 2'd0;
         dec_value = 9'd0;
      end
   endfunction

   always @(posedge clock) begin
      decoded_type seen;
      decoded_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.out_byte, rsp_chan.run_last, rsp_chan.string_done};
         if (expected_bytes.size() == 0) begin
            $display("%0t unexpected response: expected none, got byte %02h last %0b done %0b",
                     $time, seen.out_byte, seen.run_last, seen.string_done);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (seen !== want) begin
               $write("%0t mismatch: expected byte %02h last %0b done %0b,",
                      $time, want.out_byte, want.run_last, want.string_done);
               $display(" got byte %02h last %0b done %0b",
                        seen.out_byte, seen.run_last, seen.string_done);
               error_count++;
            end
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("c_escape_sequence_decoder test failed");
      $finish;
   end

   task automatic send_request(input logic [7:0] b, input logic eos);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.end_of_string <= eos;
      do @(posedge clock); while (!req_chan.ready);
      decode_request(b, eos);
      sent_count++;
   endtask

   task automatic send_buffer();
      foreach (text_bytes[i]) send_request(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic send_text(input string s);
      text_bytes.delete();
      for (int i = 0; i < s.len(); i++) add_text(s[i]);
      send_buffer();
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
   endtask

   function automatic logic [7:0] random_hex_digit();
      int v;
      v = $urandom_range(15);
      if (v < 10) return CHAR_ZERO + 8'(v);
      return ($urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(v - 10);
   endfunction

   function automatic void build_random_string();
      int pieces;
      int digits;
      text_bytes.delete();
      pieces = $urandom_range(1, 6);
      repeat (pieces) begin
         case ($urandom_range(9))
            0: add_text(8'($urandom_range(255)));
            1, 2: add_text(8'($urandom_range(32, 91)));
            3: begin
               add_text(CHAR_BACKSLASH);
               add_text(SIMPLE_ESC[$urandom_range(9)]);
            end
            4, 5: begin
               add_text(CHAR_BACKSLASH);
               add_text(CHAR_X);
               digits = $urandom_range(2);
               repeat (digits) add_text(random_hex_digit());
            end
            6, 7: begin
               add_text(CHAR_BACKSLASH);
               digits = $urandom_range(1, 3);
               repeat (digits) add_text(CHAR_ZERO + 8'($urandom_range(7)));
            end
            8: begin
               add_text(CHAR_BACKSLASH);
               add_text(8'($urandom_range(255)));
            end
            default: add_text(CHAR_BACKSLASH);
         endcase
      end
   endfunction

   task automatic test_plain_extremes();
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);
   endtask

   task automatic test_digit_runs();
      send_text("\\xAf");
      send_text("\\777");
      send_text("\\x4g");
      send_text("\\1\\n");
   endtask

   task automatic test_odd_escapes();
      send_text("\\xz");
      send_text("\\8");
      send_text("\\");
      send_text("\\x");
      send_text("\\7");
   endtask

   task automatic test_random_strings(input int count);
      int target;
      target = sent_count + count;
      while (sent_count < target) begin
         build_random_string();
         send_buffer();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.end_of_string = 1'b0;
      dec_mode = MODE_PLAIN;
      dec_digits = 2'd0;
      dec_value = 9'd0;
      sent_count = 0;
      send_idle_pct = 24;
      recv_idle_pct = 68;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_extremes();
      test_digit_runs();
      test_odd_escapes();
      wait_for_drain();
      test_random_strings(110);
      wait_for_drain();

      send_idle_pct = 68;
      recv_idle_pct = 24;
      test_random_strings(110);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_strings(110);
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("c_escape_sequence_decoder test passed");
      end else begin
         $display("c_escape_sequence_decoder test failed");
      end
      $finish;
   end

endmodule
